// ===== sv/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes and control structs of the strongly connected component counter.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int IW  = (ECW > NCW) ? ECW : NCW;
    localparam int SKW = NW + 2 * ECW;

    typedef struct packed {
        logic           go;
        logic [NCW-1:0] nodes;
        logic [ECW-1:0] edges;
    } t_scc_cmd;

    typedef struct packed {
        logic           done;
        logic [NCW-1:0] groups;
    } t_scc_rsp;

endpackage

`default_nettype wire

// ===== sv/scc_ram.sv =====
// ----------------------------------------------------------------------------
// scc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/scc_core.sv =====
// ----------------------------------------------------------------------------
// scc_core
// Builds forward and reversed adjacency lists from the edge memory, then runs
// the two depth-first passes of Kosaraju's method with a stack in memory.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_core
    import scc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_scc_cmd         i_cmd,
    output t_scc_rsp              o_rsp,
    output logic      [EAW-1:0]   o_edge_addr,
    input  wire logic [2*NW-1:0]  i_edge_data
);

    typedef enum logic [25:0] {
        S_IDLE   = 26'h0000001,
        S_CLR_ST = 26'h0000002,
        S_CNT_RD = 26'h0000004,
        S_CNT_E  = 26'h0000008,
        S_CNT_UP = 26'h0000010,
        S_PFX_RD = 26'h0000020,
        S_PFX_WR = 26'h0000040,
        S_FIL_RD = 26'h0000080,
        S_FIL_E  = 26'h0000100,
        S_FIL_W  = 26'h0000200,
        S_VCLR   = 26'h0000400,
        S_P1_RD  = 26'h0000800,
        S_P1_CHK = 26'h0001000,
        S_P2_RD  = 26'h0002000,
        S_P2_U   = 26'h0004000,
        S_P2_CHK = 26'h0008000,
        S_ROOT   = 26'h0010000,
        S_RT1    = 26'h0020000,
        S_RT2    = 26'h0040000,
        S_W_CHK  = 26'h0080000,
        S_W_LST  = 26'h0100000,
        S_W_VIS  = 26'h0200000,
        S_W_S1   = 26'h0400000,
        S_W_S2   = 26'h0800000,
        S_W_POP  = 26'h1000000,
        S_DONE   = 26'h2000000
    } t_state;

    t_state         r_state, n_state;
    logic           r_dir, n_dir;
    logic           r_pass, n_pass;
    logic [IW-1:0]  r_i, n_i;
    logic [NW-1:0]  r_a, n_a;
    logic [NW-1:0]  r_b, n_b;
    logic [ECW-1:0] r_acc, n_acc;
    logic [NW-1:0]  r_u, n_u;
    logic [ECW-1:0] r_c, n_c;
    logic [ECW-1:0] r_e, n_e;
    logic [NW-1:0]  r_v, n_v;
    logic [NCW-1:0] r_sp, n_sp;
    logic [NCW-1:0] r_ord, n_ord;
    logic [NCW-1:0] r_grp, n_grp;
    logic [NCW-1:0] r_n, n_n;
    logic [ECW-1:0] r_edges, n_edges;

    logic           st_we;
    logic [NCW-1:0] st_waddr, st_raddr;
    logic [ECW-1:0] st_wdata, st_q;
    logic [ECW-1:0] st_q_d [2];

    logic           pos_we;
    logic [NCW-1:0] pos_waddr, pos_raddr;
    logic [ECW-1:0] pos_wdata, pos_q;

    logic           ls_we;
    logic [EAW-1:0] ls_waddr, ls_raddr;
    logic [NW-1:0]  ls_wdata, ls_q;
    logic [NW-1:0]  ls_q_d [2];

    logic           vis_we, vis_wdata, vis_q;
    logic [NW-1:0]  vis_waddr, vis_raddr;

    logic           fin_we;
    logic [NW-1:0]  fin_waddr, fin_raddr, fin_wdata, fin_q;

    logic           stk_we;
    logic [NW-1:0]  stk_waddr, stk_raddr;
    logic [SKW-1:0] stk_wdata, stk_q;

    logic [NW-1:0]  e_src, e_dst, e_from, e_to;
    logic           e_ok;

    assign e_src  = i_edge_data[2*NW-1:NW];
    assign e_dst  = i_edge_data[NW-1:0];
    assign e_ok   = (NCW'(e_src) < r_n) && (NCW'(e_dst) < r_n);
    assign e_from = r_dir ? e_dst : e_src;
    assign e_to   = r_dir ? e_src : e_dst;

    assign st_q = st_q_d[r_dir];
    assign ls_q = ls_q_d[r_dir];

    assign o_edge_addr  = r_i[EAW-1:0];
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.groups = r_grp;

    for (genvar d = 0; d < 2; d++) begin : g_dir
        scc_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES + 1)) u_start (
            .i_clk  (i_clk),
            .i_we   (st_we && (r_dir == 1'(d))),
            .i_waddr(st_waddr),
            .i_wdata(st_wdata),
            .i_raddr(st_raddr),
            .o_rdata(st_q_d[d])
        );
        scc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_list (
            .i_clk  (i_clk),
            .i_we   (ls_we && (r_dir == 1'(d))),
            .i_waddr(ls_waddr),
            .i_wdata(ls_wdata),
            .i_raddr(ls_raddr),
            .o_rdata(ls_q_d[d])
        );
    end

    scc_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES + 1)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_q)
    );

    scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_raddr(vis_raddr), .o_rdata(vis_q)
    );

    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_finish (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(fin_wdata),
        .i_raddr(fin_raddr), .o_rdata(fin_q)
    );

    scc_ram #(.WIDTH(SKW), .DEPTH(MAX_NODES)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_q)
    );

    always_comb begin
        n_state = r_state;
        n_dir   = r_dir;
        n_pass  = r_pass;
        n_i     = r_i;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_u     = r_u;
        n_c     = r_c;
        n_e     = r_e;
        n_v     = r_v;
        n_sp    = r_sp;
        n_ord   = r_ord;
        n_grp   = r_grp;
        n_n     = r_n;
        n_edges = r_edges;

        st_we     = 1'b0;
        st_waddr  = r_i[NCW-1:0];
        st_wdata  = '0;
        st_raddr  = r_i[NCW-1:0];
        pos_we    = 1'b0;
        pos_waddr = r_i[NCW-1:0];
        pos_wdata = '0;
        pos_raddr = NCW'(e_from);
        ls_we     = 1'b0;
        ls_waddr  = pos_q[EAW-1:0];
        ls_wdata  = r_b;
        ls_raddr  = r_c[EAW-1:0];
        vis_we    = 1'b0;
        vis_waddr = r_i[NW-1:0];
        vis_wdata = 1'b0;
        vis_raddr = r_i[NW-1:0];
        fin_we    = 1'b0;
        fin_waddr = r_ord[NW-1:0];
        fin_wdata = r_u;
        fin_raddr = r_i[NW-1:0];
        stk_we    = 1'b0;
        stk_waddr = r_sp[NW-1:0];
        stk_wdata = {r_u, r_c, r_e};
        stk_raddr = r_sp[NW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_cmd.go) begin
                    n_n     = i_cmd.nodes;
                    n_edges = i_cmd.edges;
                    n_dir   = 1'b0;
                    n_pass  = 1'b0;
                    n_i     = '0;
                    n_grp   = '0;
                    n_ord   = '0;
                    n_state = S_CLR_ST;
                end
            end
            S_CLR_ST: begin
                st_we  = 1'b1;
                pos_we = 1'b1;
                if (r_i == IW'(MAX_NODES)) begin
                    n_i     = '0;
                    n_state = S_CNT_RD;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            S_CNT_RD: begin
                if (r_i == IW'(r_edges)) begin
                    n_i     = IW'(1);
                    n_acc   = '0;
                    n_state = S_PFX_RD;
                end else begin
                    n_state = S_CNT_E;
                end
            end
            S_CNT_E: begin
                n_a      = e_from;
                st_raddr = NCW'(e_from) + NCW'(1);
                if (e_ok) begin
                    n_state = S_CNT_UP;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_UP: begin
                st_we    = 1'b1;
                st_waddr = NCW'(r_a) + NCW'(1);
                st_wdata = st_q + ECW'(1);
                n_i      = r_i + IW'(1);
                n_state  = S_CNT_RD;
            end
            S_PFX_RD: begin
                if (r_i > IW'(r_n)) begin
                    n_i     = '0;
                    n_state = S_FIL_RD;
                end else begin
                    n_state = S_PFX_WR;
                end
            end
            S_PFX_WR: begin
                n_acc     = r_acc + st_q;
                st_we     = 1'b1;
                st_wdata  = r_acc + st_q;
                pos_we    = 1'b1;
                pos_wdata = r_acc + st_q;
                n_i       = r_i + IW'(1);
                n_state   = S_PFX_RD;
            end
            S_FIL_RD: begin
                if (r_i == IW'(r_edges)) begin
                    n_i = '0;
                    if (r_dir) begin
                        n_dir   = 1'b0;
                        n_state = S_VCLR;
                    end else begin
                        n_dir   = 1'b1;
                        n_state = S_CLR_ST;
                    end
                end else begin
                    n_state = S_FIL_E;
                end
            end
            S_FIL_E: begin
                n_a = e_from;
                n_b = e_to;
                if (e_ok) begin
                    n_state = S_FIL_W;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_FIL_RD;
                end
            end
            S_FIL_W: begin
                ls_we     = 1'b1;
                pos_we    = 1'b1;
                pos_waddr = NCW'(r_a);
                pos_wdata = pos_q + ECW'(1);
                n_i       = r_i + IW'(1);
                n_state   = S_FIL_RD;
            end
            S_VCLR: begin
                vis_we = 1'b1;
                if (r_i == IW'(MAX_NODES - 1)) begin
                    if (r_pass) begin
                        n_i     = IW'(r_ord);
                        n_state = S_P2_RD;
                    end else begin
                        n_i     = '0;
                        n_state = S_P1_RD;
                    end
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            S_P1_RD: begin
                n_u = r_i[NW-1:0];
                if (r_i == IW'(r_n)) begin
                    n_pass  = 1'b1;
                    n_dir   = 1'b1;
                    n_i     = '0;
                    n_state = S_VCLR;
                end else begin
                    n_state = S_P1_CHK;
                end
            end
            S_P1_CHK: begin
                if (!vis_q) begin
                    n_state = S_ROOT;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_P1_RD;
                end
            end
            S_P2_RD: begin
                fin_raddr = NW'(r_i - IW'(1));
                if (r_i == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_P2_U;
                end
            end
            S_P2_U: begin
                n_u       = fin_q;
                vis_raddr = fin_q;
                n_state   = S_P2_CHK;
            end
            S_P2_CHK: begin
                if (!vis_q) begin
                    n_grp   = r_grp + NCW'(1);
                    n_state = S_ROOT;
                end else begin
                    n_i     = r_i - IW'(1);
                    n_state = S_P2_RD;
                end
            end
            S_ROOT: begin
                vis_we    = 1'b1;
                vis_waddr = r_u;
                vis_wdata = 1'b1;
                st_raddr  = NCW'(r_u);
                n_state   = S_RT1;
            end
            S_RT1: begin
                n_c      = st_q;
                st_raddr = NCW'(r_u) + NCW'(1);
                n_state  = S_RT2;
            end
            S_RT2: begin
                n_e     = st_q;
                n_sp    = NCW'(1);
                n_state = S_W_CHK;
            end
            S_W_CHK: begin
                if (r_c < r_e) begin
                    n_state = S_W_LST;
                end else begin
                    if (!r_pass) begin
                        fin_we = 1'b1;
                        n_ord  = r_ord + NCW'(1);
                    end
                    stk_raddr = NW'(r_sp - NCW'(2));
                    n_sp      = r_sp - NCW'(1);
                    if (r_sp == NCW'(1)) begin
                        if (r_pass) begin
                            n_i     = r_i - IW'(1);
                            n_state = S_P2_RD;
                        end else begin
                            n_i     = r_i + IW'(1);
                            n_state = S_P1_RD;
                        end
                    end else begin
                        n_state = S_W_POP;
                    end
                end
            end
            S_W_LST: begin
                n_v       = ls_q;
                n_c       = r_c + ECW'(1);
                vis_raddr = ls_q;
                n_state   = S_W_VIS;
            end
            S_W_VIS: begin
                if (!vis_q && (r_sp < NCW'(MAX_NODES))) begin
                    vis_we    = 1'b1;
                    vis_waddr = r_v;
                    vis_wdata = 1'b1;
                    stk_we    = 1'b1;
                    stk_waddr = NW'(r_sp - NCW'(1));
                    n_u       = r_v;
                    st_raddr  = NCW'(r_v);
                    n_state   = S_W_S1;
                end else begin
                    n_state = S_W_CHK;
                end
            end
            S_W_S1: begin
                n_c      = st_q;
                st_raddr = NCW'(r_u) + NCW'(1);
                n_state  = S_W_S2;
            end
            S_W_S2: begin
                n_e     = st_q;
                n_sp    = r_sp + NCW'(1);
                n_state = S_W_CHK;
            end
            S_W_POP: begin
                {n_u, n_c, n_e} = stk_q;
                n_state         = S_W_CHK;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dir   <= n_dir;
        r_pass  <= n_pass;
        r_i     <= n_i;
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_u     <= n_u;
        r_c     <= n_c;
        r_e     <= n_e;
        r_v     <= n_v;
        r_sp    <= n_sp;
        r_ord   <= n_ord;
        r_grp   <= n_grp;
        r_n     <= n_n;
        r_edges <= n_edges;
    end

endmodule

`default_nettype wire

// ===== sv/strongly_connected_component_count.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_component_count
// Counts strongly connected components of a loaded directed graph.
// ----------------------------------------------------------------------------
// Edge requests: one per cycle while busy is low, no result, busy stays low.
// Finish request: busy through list building in both directions, two clears of all
//   1024 visited entries, and the two walks, which go edge step by edge step;
//   the single memory ports of the start, list and visited memories set the pace.
// Result: o_result_strobe for one cycle as busy falls; the receiver cannot stall.
// Reset: synchronous, active low; edge store empty, node_count is 1.
`default_nettype none

module strongly_connected_component_count
    import scc_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic           i_op,
    input  wire logic [NW-1:0]  i_source_node,
    input  wire logic [NW-1:0]  i_target_node,
    output logic                o_result_strobe,
    output logic      [NCW-1:0] o_group_count,
    output logic                o_edge_overflow,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [NCW-1:0] i_cfg_data
);

    logic           r_busy;
    logic           r_go;
    logic           r_ovf;
    logic [ECW-1:0] r_held;
    logic [NCW-1:0] r_node_count;
    logic           r_strobe;
    logic [NCW-1:0] r_grp_out;
    logic           r_ovf_out;
    logic           take, edge_we;
    logic [2*NW-1:0] edge_q;
    logic [EAW-1:0] edge_raddr;
    t_scc_cmd       cmd;
    t_scc_rsp       rsp;

    assign take        = start && !r_busy;
    assign edge_we     = take && !i_op && (r_held < ECW'(MAX_EDGES));
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    assign o_result_strobe = r_strobe;
    assign o_group_count   = r_grp_out;
    assign o_edge_overflow = r_ovf_out;

    assign cmd.go    = r_go;
    assign cmd.nodes = (r_node_count > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : r_node_count;
    assign cmd.edges = r_held;

    scc_ram #(.WIDTH(2 * NW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk  (i_clk),
        .i_we   (edge_we),
        .i_waddr(r_held[EAW-1:0]),
        .i_wdata({i_source_node, i_target_node}),
        .i_raddr(edge_raddr),
        .o_rdata(edge_q)
    );

    scc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_rsp      (rsp),
        .o_edge_addr(edge_raddr),
        .i_edge_data(edge_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_go         <= 1'b0;
            r_ovf        <= 1'b0;
            r_held       <= '0;
            r_node_count <= NCW'(1);
            r_strobe     <= 1'b0;
        end else begin
            r_go     <= take && i_op;
            r_strobe <= rsp.done;
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            if (take && i_op) begin
                r_busy <= 1'b1;
            end else if (edge_we) begin
                r_held <= r_held + ECW'(1);
            end else if (take) begin
                r_ovf <= 1'b1;
            end
            if (rsp.done) begin
                r_busy <= 1'b0;
                r_held <= '0;
                r_ovf  <= 1'b0;
            end
        end
        if (rsp.done) begin
            r_grp_out <= rsp.groups;
            r_ovf_out <= r_ovf;
        end
    end

endmodule

`default_nettype wire

// ===== sv/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_port_checker
// Port-level checks of the command handshake and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_port_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_op,
    input wire logic o_result_strobe
);

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op |=> busy)
        else $error("finish request did not raise busy");

    a_edge_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_op |=> !busy)
        else $error("edge request raised busy");

    a_fall_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_strobe)
        else $error("busy fell without a result");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe longer than one cycle");

endmodule

bind strongly_connected_component_count scc_port_checker u_scc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_op           (i_op),
    .o_result_strobe(o_result_strobe)
);

`default_nettype wire

// ===== bench/scc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_tb_pkg
// Request codes shared by the component counter bench and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package scc_tb_pkg;

    typedef enum logic {
        OP_EDGE   = 1'b0,
        OP_FINISH = 1'b1
    } t_scc_op;

endpackage

// ===== bench/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_checker
// Watches the request, result and register channels of the component counter,
// keeps its own graph copy, predicts each count and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scc_checker
    import scc_pkg::*;
    import scc_tb_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_busy,
    input  wire logic           i_op,
    input  wire logic [NW-1:0]  i_source_node,
    input  wire logic [NW-1:0]  i_target_node,
    input  wire logic           i_result_strobe,
    input  wire logic [NCW-1:0] i_group_count,
    input  wire logic           i_edge_overflow,
    input  wire logic           i_cfg_valid,
    input  wire logic           i_cfg_ready,
    input  wire logic [NCW-1:0] i_cfg_data,
    output int                  o_pending,
    output int                  o_errors
);

    typedef struct packed {
        logic [NCW-1:0] groups;
        logic           overflow;
    } t_count_rsp;

    logic [NW-1:0]  edge_src [$];
    logic [NW-1:0]  edge_dst [$];
    logic           overflow_flag;
    logic [NCW-1:0] node_cfg;
    t_count_rsp     expected_counts [$];

    int        fwd_head [0:MAX_NODES];
    int        rev_head [0:MAX_NODES];
    int        fwd_next [0:MAX_EDGES-1];
    int        rev_next [0:MAX_EDGES-1];
    int        fill_pos [0:MAX_NODES];
    bit        seen [0:MAX_NODES-1];
    int        stk_node [0:MAX_NODES-1];
    int        stk_cur [0:MAX_NODES-1];
    int        finish_seq [$];

    function void dfs(int root, bit reversed, bit record);
        int sp;
        int u;
        int c;
        int v;
        int lim;
        seen[root] = 1;
        stk_node[0] = root;
        stk_cur[0] = reversed ? rev_head[root] : fwd_head[root];
        sp = 1;
        while (sp > 0) begin
            u = stk_node[sp-1];
            c = stk_cur[sp-1];
            lim = reversed ? rev_head[u+1] : fwd_head[u+1];
            if (c < lim) begin
                stk_cur[sp-1] = c + 1;
                v = reversed ? rev_next[c] : fwd_next[c];
                if (!seen[v]) begin
                    seen[v] = 1;
                    stk_node[sp] = v;
                    stk_cur[sp] = reversed ? rev_head[v] : fwd_head[v];
                    sp++;
                end
            end else begin
                sp--;
                if (record) finish_seq.insert(finish_seq.size(), u);
            end
        end
    endfunction

    function int count_components(int n);
        int groups;
        int s;
        int t;
        groups = 0;
        for (int i = 0; i <= MAX_NODES; i++) begin
            fwd_head[i] = 0;
            rev_head[i] = 0;
        end
        foreach (edge_src[i]) begin
            s = edge_src[i];
            t = edge_dst[i];
            if (s < n && t < n) begin
                fwd_head[s+1]++;
                rev_head[t+1]++;
            end
        end
        for (int i = 0; i < n; i++) begin
            fwd_head[i+1] += fwd_head[i];
            rev_head[i+1] += rev_head[i];
        end
        for (int i = 0; i <= MAX_NODES; i++) fill_pos[i] = fwd_head[i];
        foreach (edge_src[i]) begin
            s = edge_src[i];
            t = edge_dst[i];
            if (s < n && t < n) begin
                fwd_next[fill_pos[s]] = t;
                fill_pos[s]++;
            end
        end
        for (int i = 0; i <= MAX_NODES; i++) fill_pos[i] = rev_head[i];
        foreach (edge_src[i]) begin
            s = edge_src[i];
            t = edge_dst[i];
            if (s < n && t < n) begin
                rev_next[fill_pos[t]] = s;
                fill_pos[t]++;
            end
        end
        finish_seq.delete();
        for (int i = 0; i < MAX_NODES; i++) seen[i] = 0;
        for (int i = 0; i < n; i++)
            if (!seen[i]) dfs(i, 1'b0, 1'b1);
        for (int i = 0; i < MAX_NODES; i++) seen[i] = 0;
        for (int i = finish_seq.size() - 1; i >= 0; i--) begin
            if (!seen[finish_seq[i]]) begin
                groups++;
                dfs(finish_seq[i], 1'b1, 1'b0);
            end
        end
        return groups;
    endfunction

    always @(posedge i_clk) begin
        t_count_rsp want;
        int         n;
        int         errs;
        if (!i_rst_n) begin
            edge_src.delete();
            edge_dst.delete();
            expected_counts.delete();
            overflow_flag = 1'b0;
            node_cfg = NCW'(1);
            o_pending <= 0;
            o_errors <= 0;
        end else begin
            errs = 0;
            if (i_result_strobe) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected result groups=%0d overflow=%0b",
                             $time, i_group_count, i_edge_overflow);
                    errs++;
                end else begin
                    want = expected_counts.pop_front();
                    if (want.groups !== i_group_count) begin
                        $display("%0t: group_count expected %0d actual %0d",
                                 $time, want.groups, i_group_count);
                        errs++;
                    end
                    if (want.overflow !== i_edge_overflow) begin
                        $display("%0t: edge_overflow expected %0b actual %0b",
                                 $time, want.overflow, i_edge_overflow);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_errors <= o_errors + errs;
            if (i_cfg_valid && i_cfg_ready) node_cfg = i_cfg_data;
            if (i_start && !i_busy) begin
                if (i_op == OP_EDGE) begin
                    if (edge_src.size() < MAX_EDGES) begin
                        edge_src.insert(edge_src.size(), i_source_node);
                        edge_dst.insert(edge_dst.size(), i_target_node);
                    end else begin
                        overflow_flag = 1'b1;
                    end
                end else begin
                    n = (node_cfg > MAX_NODES) ? MAX_NODES : node_cfg;
                    want.groups = NCW'(count_components(n));
                    want.overflow = overflow_flag;
                    expected_counts.insert(expected_counts.size(), want);
                    edge_src.delete();
                    edge_dst.delete();
                    overflow_flag = 1'b0;
                end
            end
            o_pending <= expected_counts.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives graphs into the component counter: a directed set of small graphs and
// register extremes, then random graphs under varying request gaps. The
// checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import scc_pkg::*;
    import scc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int RANDOM_ITEMS = 1330;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    logic           i_op = OP_EDGE;
    logic [NW-1:0]  i_source_node = '0;
    logic [NW-1:0]  i_target_node = '0;
    logic           o_result_strobe;
    logic [NCW-1:0] o_group_count;
    logic           o_edge_overflow;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [NCW-1:0] i_cfg_data = '0;

    int   pending;
    int   errors;
    int   cycles = 0;
    int   gap_pct = 0;
    int   sent = 0;
    logic req_took = 1'b0;
    logic cfg_took = 1'b0;

    always #2 i_clk = ~i_clk;

    strongly_connected_component_count u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_source_node  (i_source_node),
        .i_target_node  (i_target_node),
        .o_result_strobe(o_result_strobe),
        .o_group_count  (o_group_count),
        .o_edge_overflow(o_edge_overflow),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    scc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_source_node  (i_source_node),
        .i_target_node  (i_target_node),
        .i_result_strobe(o_result_strobe),
        .i_group_count  (o_group_count),
        .i_edge_overflow(o_edge_overflow),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    always @(posedge i_clk) begin
        req_took <= start && !busy;
        cfg_took <= i_cfg_valid && o_cfg_ready;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("strongly_connected_component_count verification failed");
            $finish;
        end
    end

    task automatic send_request(input t_scc_op op, input logic [NW-1:0] s,
                                input logic [NW-1:0] t);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_source_node <= s;
        i_target_node <= t;
        do @(negedge i_clk); while (!req_took);
        sent++;
    endtask

    // hold off until every count is back and the block has settled
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_nodes(input logic [NCW-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(negedge i_clk); while (!cfg_took);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [NCW-1:0] pick_nodes();
        int r;
        r = $urandom_range(99);
        if (r < 3) return NCW'(0);
        if (r < 6) return NCW'(MAX_NODES);
        if (r < 8) return NCW'(2047);
        if (r < 12) return NCW'($urandom_range(17, 2047));
        return NCW'($urandom_range(1, 16));
    endfunction

    task automatic random_graph(input int n);
        int cnt;
        int lim;
        lim = (n < 1) ? 1 : ((n > MAX_NODES) ? MAX_NODES : n);
        cnt = $urandom_range(0, 3 * lim > 40 ? 40 : 3 * lim);
        for (int k = 0; k < cnt; k++) begin
            if ($urandom_range(99) < 85)
                send_request(OP_EDGE, NW'($urandom_range(lim - 1)),
                             NW'($urandom_range(lim - 1)));
            else
                send_request(OP_EDGE, NW'($urandom), NW'($urandom));
        end
        send_request(OP_FINISH, NW'($urandom), NW'($urandom));
    endtask

    initial begin
        logic [NCW-1:0] nodes;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(OP_FINISH, '0, '0);
        write_nodes(NCW'(0));
        send_request(OP_EDGE, '0, '0);
        send_request(OP_FINISH, '0, '0);
        write_nodes(NCW'(4));
        send_request(OP_EDGE, NW'(0), NW'(1));
        send_request(OP_EDGE, NW'(1), NW'(2));
        send_request(OP_EDGE, NW'(2), NW'(0));
        send_request(OP_EDGE, NW'(2), NW'(3));
        send_request(OP_EDGE, NW'(3), NW'(3));
        send_request(OP_EDGE, NW'(5), NW'(1));
        send_request(OP_FINISH, '1, '1);
        write_nodes(NCW'(2047));
        send_request(OP_EDGE, '1, '0);
        send_request(OP_EDGE, '0, '1);
        send_request(OP_FINISH, '0, '0);
        write_nodes(NCW'(MAX_NODES));
        send_request(OP_EDGE, '1, '1);
        send_request(OP_EDGE, 10'h2AA, 10'h155);
        send_request(OP_FINISH, '0, '0);

        nodes = NCW'(8);
        write_nodes(nodes);
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ((sent / 340) % 4)
                0: gap_pct = 0;
                1: gap_pct = 61;
                2: gap_pct = 35;
                default: gap_pct = 0;
            endcase
            if ($urandom_range(99) < 35) begin
                nodes = pick_nodes();
                write_nodes(nodes);
            end
            random_graph(int'(nodes));
        end

        drain();
        if (errors == 0)
            $display("strongly_connected_component_count verification clean");
        else
            $display("strongly_connected_component_count verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/scc_pkg.sv
sv/scc_ram.sv
sv/scc_core.sv
sv/strongly_connected_component_count.sv
sv/scc_checker.sv
bench/scc_tb_pkg.sv
bench/scc_checker.sv
bench/tb_top.sv
